/* sv/mlfq_pkg.sv */
package mlfq_pkg;

  localparam int unsigned LEVELS_DEF = 6;
  localparam int unsigned MAX_THREADS_DEF = 64;
  localparam logic [15:0] BOOST_PERIOD_RST = 16'd100;

  localparam logic [2:0] OP_ADMIT = 3'd0;
  localparam logic [2:0] OP_PREEMPT = 3'd1;
  localparam logic [2:0] OP_FINISH = 3'd2;
  localparam logic [2:0] OP_BLOCK = 3'd3;
  localparam logic [2:0] OP_WAKE = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_KNOWN = 2'd1;
  localparam logic [1:0] ST_NORUN = 2'd2;
  localparam logic [1:0] ST_UNKNOWN = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVENT,
    S_BOOST,
    S_DISP,
    S_DLINK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic event_go;
    logic boost_step;
    logic disp_go;
    logic disp_link;
  } cmd_t;

  typedef struct packed {
    logic is_sched;
    logic do_boost;
    logic boost_done;
    logic need_link;
  } sts_t;

endpackage

/* sv/mlfq_dp.sv */
module mlfq_dp #(
  parameter int unsigned LEVELS = mlfq_pkg::LEVELS_DEF,
  parameter int unsigned MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  mlfq_pkg::cmd_t   cmd,
  output mlfq_pkg::sts_t   sts,
  input  logic [2:0]       in_opcode,
  input  logic [5:0]       in_thread_id,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_boost_period,
  output logic             res_running_valid,
  output logic [5:0]       res_running_id,
  output logic [2:0]       res_running_level,
  output logic             res_boosted,
  output logic [1:0]       res_status
);
  import mlfq_pkg::*;

  localparam int unsigned TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int unsigned LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [LW-1:0] LAST = LW'(LEVELS - 1);

  logic [TW-1:0] link_mem [MAX_THREADS];
  logic [2:0] lvl_r [MAX_THREADS];
  logic [MAX_THREADS-1:0] lvl_ok_r;
  logic [MAX_THREADS-1:0] known_r, queued_r;
  logic [TW-1:0] head_r [LEVELS];
  logic [TW-1:0] tail_r [LEVELS];
  logic [LEVELS-1:0] nonempty_r;
  logic [TW-1:0] cur_r;
  logic [2:0] cur_lvl_r;
  logic cur_valid_r;
  logic [15:0] count_r, period_r;
  logic [2:0] op_r;
  logic [5:0] tid_r;
  logic [LW-1:0] tid_lvl_r;
  logic [1:0] status_r;
  logic boosted_r;
  logic [LW-1:0] bl_r, dl_r;
  logic [TW-1:0] link_rd_r;

  logic tid_ok;
  logic [TW-1:0] tid_t;
  logic [15:0] count_inc;
  logic [LW-1:0] first_lvl;
  logic any_ne;

  assign tid_ok = ({3'b0, tid_r} < 9'(MAX_THREADS));
  assign tid_t = TW'(tid_r);
  assign count_inc = count_r + 16'd1;

  always_comb begin
    first_lvl = '0;
    any_ne = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (nonempty_r[i]) begin
        first_lvl = LW'(i);
        any_ne = 1'b1;
      end
    end
  end

  assign sts.is_sched = (op_r == OP_PREEMPT) || (op_r == OP_FINISH) || (op_r == OP_BLOCK);
  assign sts.do_boost = (count_inc >= period_r);
  assign sts.boost_done = (bl_r == LAST);
  assign sts.need_link = any_ne && (head_r[first_lvl] != tail_r[first_lvl]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= BOOST_PERIOD_RST;
      known_r <= '0;
      queued_r <= '0;
      nonempty_r <= '0;
      cur_r <= '0;
      cur_lvl_r <= '0;
      cur_valid_r <= 1'b0;
      count_r <= '0;
      lvl_ok_r <= '0;
    end else begin
      if (cfg_we) period_r <= cfg_boost_period;
      if (cmd.load) begin
        op_r <= in_opcode;
        tid_r <= in_thread_id;
        tid_lvl_r <= lvl_ok_r[TW'(in_thread_id)] ? LW'(lvl_r[TW'(in_thread_id)]) : '0;
        boosted_r <= 1'b0;
        status_r <= ST_OK;
        bl_r <= LW'(1);
      end
      if (cmd.event_go) begin
        if (op_r == OP_ADMIT) begin
          if (!tid_ok) status_r <= ST_UNKNOWN;
          else if (known_r[tid_t]) status_r <= ST_KNOWN;
          else begin
            known_r[tid_t] <= 1'b1;
            lvl_ok_r[tid_t] <= 1'b0;
            queued_r[tid_t] <= 1'b1;
            if (nonempty_r[0]) link_mem[tail_r[0]] <= tid_t;
            else head_r[0] <= tid_t;
            tail_r[0] <= tid_t;
            nonempty_r[0] <= 1'b1;
          end
        end else if (op_r == OP_WAKE) begin
          if (!tid_ok || !known_r[tid_t]) status_r <= ST_UNKNOWN;
          else if (queued_r[tid_t] || (cur_valid_r && cur_r == tid_t)) status_r <= ST_KNOWN;
          else begin
            queued_r[tid_t] <= 1'b1;
            if (nonempty_r[tid_lvl_r]) link_mem[tail_r[tid_lvl_r]] <= tid_t;
            else head_r[tid_lvl_r] <= tid_t;
            tail_r[tid_lvl_r] <= tid_t;
            nonempty_r[tid_lvl_r] <= 1'b1;
          end
        end else if (sts.is_sched) begin
          if (!cur_valid_r) status_r <= ST_NORUN;
          else if (op_r == OP_PREEMPT) begin
            logic [LW-1:0] nl;
            nl = (LW'(cur_lvl_r) == LAST) ? LAST : LW'(cur_lvl_r) + LW'(1);
            lvl_r[cur_r] <= 3'(nl);
            if (!sts.do_boost) lvl_ok_r[cur_r] <= 1'b1;
            queued_r[cur_r] <= 1'b1;
            if (nonempty_r[nl]) link_mem[tail_r[nl]] <= cur_r;
            else head_r[nl] <= cur_r;
            tail_r[nl] <= cur_r;
            nonempty_r[nl] <= 1'b1;
          end else if (op_r == OP_FINISH) begin
            known_r[cur_r] <= 1'b0;
            queued_r[cur_r] <= 1'b0;
            if (!sts.do_boost) lvl_ok_r[cur_r] <= 1'b0;
          end else begin
            queued_r[cur_r] <= 1'b0;
          end
          cur_valid_r <= 1'b0;
          cur_r <= '0;
          if (sts.do_boost) begin
            count_r <= '0;
            boosted_r <= 1'b1;
            lvl_ok_r <= '0;
          end else begin
            count_r <= count_inc;
          end
        end
      end
      if (cmd.boost_step) begin
        if (nonempty_r[bl_r]) begin
          if (nonempty_r[0]) link_mem[tail_r[bl_r]] <= head_r[0];
          else tail_r[0] <= tail_r[bl_r];
          head_r[0] <= head_r[bl_r];
          nonempty_r[0] <= 1'b1;
          nonempty_r[bl_r] <= 1'b0;
        end
        if (bl_r != LAST) bl_r <= bl_r + LW'(1);
      end
      if (cmd.disp_go) begin
        dl_r <= first_lvl;
        link_rd_r <= link_mem[head_r[first_lvl]];
        if (any_ne) begin
          queued_r[head_r[first_lvl]] <= 1'b0;
          cur_r <= head_r[first_lvl];
          cur_lvl_r <= lvl_ok_r[head_r[first_lvl]] ? lvl_r[head_r[first_lvl]] : 3'd0;
          cur_valid_r <= 1'b1;
          if (head_r[first_lvl] == tail_r[first_lvl]) nonempty_r[first_lvl] <= 1'b0;
        end
      end
      if (cmd.disp_link) head_r[dl_r] <= link_rd_r;
    end
  end

  assign res_running_valid = cur_valid_r;
  assign res_running_id = cur_valid_r ? 6'(cur_r) : 6'd0;
  assign res_running_level = cur_valid_r ? cur_lvl_r : 3'd0;
  assign res_boosted = boosted_r;
  assign res_status = status_r;

  a_cur_dequeued: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.disp_go) && cur_valid_r |-> !queued_r[cur_r])
    else $error("running thread still queued");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.event_go) && boosted_r |-> count_r == 16'd0)
    else $error("count not cleared on boost");
  a_boost_lvl0: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.boost_step && sts.boost_done |=> !(|nonempty_r[LEVELS-1:1]))
    else $error("lower level left after boost");
endmodule

/* sv/mlfq_ctrl.sv */
module mlfq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  mlfq_pkg::sts_t sts,
  output mlfq_pkg::cmd_t cmd
);
  import mlfq_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVENT;
      S_EVENT: begin
        if (!sts.is_sched) state_nxt = S_OUT;
        else if (sts.do_boost) state_nxt = S_BOOST;
        else state_nxt = S_DISP;
      end
      S_BOOST: if (sts.boost_done) state_nxt = S_DISP;
      S_DISP: state_nxt = sts.need_link ? S_DLINK : S_OUT;
      S_DLINK: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_EVENT: cmd.event_go = 1'b1;
      S_BOOST: cmd.boost_step = 1'b1;
      S_DISP: cmd.disp_go = 1'b1;
      S_DLINK: cmd.disp_link = 1'b1;
      S_OUT: out_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(cmd))
    else $error("overlapping commands");
  a_load_evt: assert property (@(posedge clk) disable iff (!rst_n) cmd.load |=> cmd.event_go)
    else $error("event not run after load");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped");
endmodule

/* sv/mlfq_thread_scheduler.sv */
// channel | valid     | stall      | payload
// in      | in_valid  | in_stall   | in_opcode, in_thread_id
// out     | out_valid | out_stall  | out_running_valid/id/level, out_boosted, out_status
// cfg     | cfg_we    | -          | cfg_boost_period
// One request at a time: admit/wake run the event step only; scheduling events
// also dispatch, after a boost merge sweep when due, plus a link step if needed.
// Synchronous active-low reset clears the thread lists and thread flags; period resets to 100.
// Result holds while out_stall is high; in_stall stays high until it is taken.
module mlfq_thread_scheduler #(
  parameter int unsigned LEVELS = mlfq_pkg::LEVELS_DEF,
  parameter int unsigned MAX_THREADS = mlfq_pkg::MAX_THREADS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [5:0]  in_thread_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_running_valid,
  output logic [5:0]  out_running_id,
  output logic [2:0]  out_running_level,
  output logic        out_boosted,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_boost_period
);
  import mlfq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mlfq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  mlfq_dp #(.LEVELS(LEVELS), .MAX_THREADS(MAX_THREADS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_opcode, .in_thread_id, .cfg_we, .cfg_boost_period,
    .res_running_valid(out_running_valid), .res_running_id(out_running_id),
    .res_running_level(out_running_level), .res_boosted(out_boosted),
    .res_status(out_status)
  );
endmodule
